@@ src/i2ctb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2ctb_pkg - shared types and constants for the I2C target buffer
// Command and status codes, register indexes, ring handshake structs and
// the filler byte selector.
// ----------------------------------------------------------------------------
package i2ctb_pkg;

	// defaults for top-level parameters
	localparam int RING_DEPTH_DEF  = 256;
	localparam int PATTERN_MAX_DEF = 4;

	// most results one bus request can produce
	localparam int MAX_RESULTS = 4;
	localparam int BYTE_W      = 8;
	localparam int PLEN_W      = 3;
	localparam int PBYTES_W    = 32;
	localparam int PBYTES_N    = PBYTES_W / BYTE_W;

	// input commands
	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_REQ  = 2'd2;
	localparam logic [1:0] CMD_RECV = 2'd3;

	// result status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_TX_FULL = 2'd1;
	localparam logic [1:0] STAT_RX_EMPTY = 2'd2;
	localparam logic [1:0] STAT_RX_DROP = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd0;
	localparam logic [1:0] CFG_PATTERN_BYTES  = 2'd1;
	localparam logic [1:0] CFG_RX_THRESHOLD   = 2'd2;

	// reset values of the configuration registers
	localparam logic [PLEN_W-1:0]   PATTERN_LENGTH_RST = 3'd3;
	localparam logic [PBYTES_W-1:0] PATTERN_BYTES_RST  = 32'h0002_0001;
	localparam logic [BYTE_W-1:0]   RX_THRESHOLD_RST   = 8'd0;

	// where the byte of a result comes from
	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_RX   = 2'd1,
		SRC_TX   = 2'd2,
		SRC_FILL = 2'd3
	} src_t;

	typedef struct packed {
		logic [PLEN_W-1:0]   pattern_length;
		logic [PBYTES_W-1:0] pattern_bytes;
		logic [BYTE_W-1:0]   rx_threshold;
	} cfg_t;

	// request into a ring: push a word, pop the head word
	typedef struct packed {
		logic              push;
		logic              pop;
		logic [BYTE_W-1:0] wdata;
	} ring_req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ring_stat_t;

	// filler byte k; bytes past the packed word read as zero
	function automatic logic [BYTE_W-1:0] fill_byte(input logic [PBYTES_W-1:0] pat,
			input logic [PLEN_W-1:0] k);
		logic [BYTE_W-1:0] b;
		b = '0;
		if ({1'b0, k} < (PLEN_W+1)'(PBYTES_N)) begin
			b = pat[k * BYTE_W +: BYTE_W];
		end
		return b;
	endfunction

endpackage

@@ src/i2ctb_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2ctb_ring - byte ring buffer
// Single-port-write, single-port-read ring holding at most DEPTH-1 words,
// with registered read data and a level derived from the two pointers.
// ----------------------------------------------------------------------------
module i2ctb_ring
	import i2ctb_pkg::*;
#(
	parameter int DEPTH = RING_DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ring_req_t         req,
	output ring_stat_t        stat,
	output logic [AW-1:0]     level,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [BYTE_W-1:0] rdata_q;
	logic [AW:0]       diff;

	// level modulo depth
	always_comb begin
		if (wr_ptr_q >= rd_ptr_q) begin
			diff = {1'b0, wr_ptr_q} - {1'b0, rd_ptr_q};
		end else begin
			diff = {1'b0, wr_ptr_q} + (AW+1)'(DEPTH) - {1'b0, rd_ptr_q};
		end
	end

	assign level      = diff[AW-1:0];
	assign stat.full  = (level == AW'(DEPTH - 1));
	assign stat.empty = (level == '0);
	assign rdata      = rdata_q;

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (req.push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (req.pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
		end
	end

	// storage, read data registered on pop
	always_ff @(posedge clk) begin
		if (req.push) begin
			mem[wr_ptr_q] <= req.wdata;
		end
		if (req.pop) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

endmodule

@@ src/i2ctb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2ctb_ctrl - command sequencer
// Decodes one command, drives the rings, tracks idle mode and the filler
// position, then issues the results one word a cycle, while the output register is free, into an output register.
// ----------------------------------------------------------------------------
module i2ctb_ctrl
	import i2ctb_pkg::*;
#(
	parameter int RING_DEPTH  = RING_DEPTH_DEF,
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	localparam int AW         = $clog2(RING_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [BYTE_W-1:0] data_in,
	input  logic [2:0]        fifo_space,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic              byte_valid,
	output logic [BYTE_W-1:0] data_out,
	output logic              last,
	output logic [BYTE_W-1:0] tx_level,
	output logic [BYTE_W-1:0] rx_level,
	output logic              rx_ready,
	output logic              tx_drained,
	output ring_req_t         tx_req,
	output ring_req_t         rx_req,
	input  ring_stat_t        tx_stat,
	input  ring_stat_t        rx_stat,
	input  logic [AW-1:0]     tx_lvl,
	input  logic [AW-1:0]     rx_lvl,
	input  logic [BYTE_W-1:0] tx_rdata,
	input  logic [BYTE_W-1:0] rx_rdata
);

	localparam int CW = (AW > BYTE_W) ? AW : BYTE_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t              state_q;
	logic [1:0]          cmd_q;
	logic [BYTE_W-1:0]   din_q;
	logic [2:0]          space_q;
	logic [1:0]          status_q;
	src_t                src_q;
	logic [2:0]          cnt_q;
	logic                send_data_q;
	logic                idle_q;
	logic [PLEN_W-1:0]   pidx_q;

	logic                out_valid_q;
	logic [1:0]          o_status_q;
	logic                o_bvalid_q;
	logic [BYTE_W-1:0]   o_data_q;
	logic                o_last_q;
	logic [BYTE_W-1:0]   o_txl_q;
	logic [BYTE_W-1:0]   o_rxl_q;
	logic                o_rdy_q;
	logic                o_drained_q;

	logic [2:0]          space_c;
	logic [PLEN_W-1:0]   plen_c;
	logic                have;
	logic                idle1;
	logic [PLEN_W-1:0]   idx1;
	logic                wrap;
	logic                idle2;
	logic [PLEN_W-1:0]   idx2;
	logic [PLEN_W-1:0]   avail;
	logic [2:0]          sent;
	logic                slot_free;
	logic [BYTE_W-1:0]   res_byte;

	assign in_ready  = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;

	// idle-mode decision for a bus request
	always_comb begin
		space_c = (space_q > 3'(MAX_RESULTS)) ? 3'(MAX_RESULTS) : space_q;
		plen_c  = ({1'b0, cfg.pattern_length} > (PLEN_W+1)'(PATTERN_MAX))
			? PLEN_W'(PATTERN_MAX) : cfg.pattern_length;
		have    = !tx_stat.empty;
		idle1   = idle_q || !have;
		idx1    = (!have && !idle_q) ? '0 : pidx_q;
		wrap    = idle1 && (idx1 >= plen_c);
		idle2   = wrap ? !have : idle1;
		idx2    = wrap ? '0 : idx1;
		avail   = plen_c - idx2;
		sent    = ({1'b0, space_c} < {1'b0, avail}) ? space_c : 3'(avail);
	end

	// ring requests, issued in the decode cycle only
	always_comb begin
		tx_req       = '0;
		rx_req       = '0;
		tx_req.wdata = din_q;
		rx_req.wdata = din_q;
		if (state_q == ST_EXEC) begin
			case (cmd_q)
				CMD_PUSH: tx_req.push = !tx_stat.full;
				CMD_POP:  rx_req.pop  = !rx_stat.empty;
				CMD_RECV: rx_req.push = !rx_stat.full;
				CMD_REQ:  tx_req.pop  = !idle2;
				default: begin
				end
			endcase
		end
	end

	// byte of the next result
	always_comb begin
		case (src_q)
			SRC_RX:   res_byte = rx_rdata;
			SRC_TX:   res_byte = tx_rdata;
			SRC_FILL: res_byte = fill_byte(cfg.pattern_bytes, pidx_q);
			default:  res_byte = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_PUSH;
			space_q     <= '0;
			status_q    <= STAT_OK;
			src_q       <= SRC_NONE;
			cnt_q       <= '0;
			send_data_q <= 1'b0;
			idle_q      <= 1'b0;
			pidx_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q   <= cmd;
						space_q <= fifo_space;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					status_q    <= STAT_OK;
					src_q       <= SRC_NONE;
					cnt_q       <= 3'd1;
					send_data_q <= 1'b0;
					case (cmd_q)
						CMD_PUSH: begin
							if (tx_stat.full) begin
								status_q <= STAT_TX_FULL;
							end
						end
						CMD_POP: begin
							if (rx_stat.empty) begin
								status_q <= STAT_RX_EMPTY;
							end else begin
								src_q <= SRC_RX;
							end
						end
						CMD_RECV: begin
							if (rx_stat.full) begin
								status_q <= STAT_RX_DROP;
							end
						end
						CMD_REQ: begin
							idle_q <= idle2;
							pidx_q <= idx2;
							if (idle2) begin
								if (sent != '0) begin
									src_q <= SRC_FILL;
									cnt_q <= sent;
								end
							end else begin
								src_q       <= SRC_TX;
								send_data_q <= 1'b1;
							end
						end
						default: begin
						end
					endcase
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						cnt_q <= cnt_q - 1'b1;
						if (src_q == SRC_FILL) begin
							pidx_q <= pidx_q + 1'b1;
						end
						if (cnt_q == 3'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pushed byte held for the ring write
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			din_q <= data_in;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload, levels taken after the ring update
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && slot_free) begin
			o_status_q  <= status_q;
			o_bvalid_q  <= (src_q != SRC_NONE);
			o_data_q    <= res_byte;
			o_last_q    <= (cnt_q == 3'd1);
			o_txl_q     <= BYTE_W'(tx_lvl);
			o_rxl_q     <= BYTE_W'(rx_lvl);
			o_rdy_q     <= (cfg.rx_threshold != '0) &&
				(CW'(rx_lvl) >= CW'(cfg.rx_threshold));
			o_drained_q <= send_data_q && tx_stat.empty;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = o_status_q;
	assign byte_valid = o_bvalid_q;
	assign data_out   = o_data_q;
	assign last       = o_last_q;
	assign tx_level   = o_txl_q;
	assign rx_level   = o_rxl_q;
	assign rx_ready   = o_rdy_q;
	assign tx_drained = o_drained_q;

endmodule

@@ src/i2c_target_buffer_with_idle_fill_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_target_buffer_with_idle_fill_top - I2C target transmit/receive buffer
// Transmit and receive byte rings with an idle filler pattern, plus the
// configuration registers.
// ----------------------------------------------------------------------------
// One command word is taken, decoded in the next cycle (ring write, ring pop
// or idle-mode update), and its results then leave one per cycle, while the
// output is not held off, through an output register; a command gives 1 to 4
// result words, and a bus request in idle mode gives one result per filler
// byte sent. The sequencer takes no new command until the last result
// has been loaded into the output register; that last word may still be
// waiting downstream when the next command is accepted. Each ring holds at
// most RING_DEPTH-1 bytes and needs no clearing after reset. Configuration
// writes are always accepted and should be made only while the block is idle.
module i2c_target_buffer_with_idle_fill_top
	import i2ctb_pkg::*;
#(
	parameter int RING_DEPTH  = RING_DEPTH_DEF,
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [PBYTES_W-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          cmd,
	input  logic [BYTE_W-1:0]   data_in,
	input  logic [2:0]          fifo_space,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic                byte_valid,
	output logic [BYTE_W-1:0]   data_out,
	output logic                last,
	output logic [BYTE_W-1:0]   tx_level,
	output logic [BYTE_W-1:0]   rx_level,
	output logic                rx_ready,
	output logic                tx_drained
);

	localparam int AW = $clog2(RING_DEPTH);

	cfg_t              cfg_q;
	ring_req_t         tx_req;
	ring_req_t         rx_req;
	ring_stat_t        tx_stat;
	ring_stat_t        rx_stat;
	logic [AW-1:0]     tx_lvl;
	logic [AW-1:0]     rx_lvl;
	logic [BYTE_W-1:0] tx_rdata;
	logic [BYTE_W-1:0] rx_rdata;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_length <= PATTERN_LENGTH_RST;
			cfg_q.pattern_bytes  <= PATTERN_BYTES_RST;
			cfg_q.rx_threshold   <= RX_THRESHOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_data[PLEN_W-1:0];
				CFG_PATTERN_BYTES:  cfg_q.pattern_bytes  <= cfg_data;
				CFG_RX_THRESHOLD:   cfg_q.rx_threshold   <= cfg_data[BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	i2ctb_ring #(
		.DEPTH (RING_DEPTH)
	) u_tx_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tx_req),
		.stat   (tx_stat),
		.level  (tx_lvl),
		.rdata  (tx_rdata)
	);

	i2ctb_ring #(
		.DEPTH (RING_DEPTH)
	) u_rx_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rx_req),
		.stat   (rx_stat),
		.level  (rx_lvl),
		.rdata  (rx_rdata)
	);

	i2ctb_ctrl #(
		.RING_DEPTH  (RING_DEPTH),
		.PATTERN_MAX (PATTERN_MAX)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.data_in    (data_in),
		.fifo_space (fifo_space),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.byte_valid (byte_valid),
		.data_out   (data_out),
		.last       (last),
		.tx_level   (tx_level),
		.rx_level   (rx_level),
		.rx_ready   (rx_ready),
		.tx_drained (tx_drained),
		.tx_req     (tx_req),
		.rx_req     (rx_req),
		.tx_stat    (tx_stat),
		.rx_stat    (rx_stat),
		.tx_lvl     (tx_lvl),
		.rx_lvl     (rx_lvl),
		.tx_rdata   (tx_rdata),
		.rx_rdata   (rx_rdata)
	);

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking testbench for i2c_target_buffer_with_idle_fill_top
// Drives host pushes and pops, bus requests and received bytes through the
// command channel and tracks both rings and the idle filler in a small model.
// Every result word is checked against the model. The run has a directed
// opening, random phases with uneven idling on both sides, then ring floods
// with a long output hold-off.
// ----------------------------------------------------------------------------
import i2ctb_pkg::*;

// one result word as it leaves the block
typedef struct packed {
	logic [1:0]        status;
	logic              byte_valid;
	logic [BYTE_W-1:0] data_out;
	logic              last;
	logic [BYTE_W-1:0] tx_level;
	logic [BYTE_W-1:0] rx_level;
	logic              rx_ready;
	logic              tx_drained;
} buf_word_t;

// ring and filler tracking, plus the words still owed by the block
class buffer_tracker;
	logic [BYTE_W-1:0]   tx_ring [RING_DEPTH_DEF];
	logic [BYTE_W-1:0]   rx_ring [RING_DEPTH_DEF];
	logic [BYTE_W-1:0]   tx_rd, tx_wr, rx_rd, rx_wr;
	logic                idle_fill;
	logic [PLEN_W-1:0]   fill_pos;
	logic [PLEN_W-1:0]   cfg_plen;
	logic [PBYTES_W-1:0] cfg_pattern;
	logic [BYTE_W-1:0]   cfg_thresh;
	buf_word_t           owed_words [$];
	int                  mismatches;

	function new();
		tx_rd       = '0;
		tx_wr       = '0;
		rx_rd       = '0;
		rx_wr       = '0;
		idle_fill   = 1'b0;
		fill_pos    = '0;
		cfg_plen    = PATTERN_LENGTH_RST;
		cfg_pattern = PATTERN_BYTES_RST;
		cfg_thresh  = RX_THRESHOLD_RST;
		mismatches  = 0;
	endfunction

	function logic [BYTE_W-1:0] fill_level(input logic [BYTE_W-1:0] rd,
			input logic [BYTE_W-1:0] wr);
		return wr - rd;
	endfunction

	function int owed();
		return owed_words.size();
	endfunction

	function void write_reg(input logic [1:0] idx, input logic [PBYTES_W-1:0] val);
		case (idx)
		CFG_PATTERN_LENGTH: cfg_plen = val[PLEN_W-1:0];
		CFG_PATTERN_BYTES:  cfg_pattern = val;
		CFG_RX_THRESHOLD:   cfg_thresh = val[BYTE_W-1:0];
		default: ;
		endcase
	endfunction

	// update the rings for one accepted command and queue the words it owes
	function void apply_command(input logic [1:0] op, input logic [BYTE_W-1:0] din,
			input logic [2:0] space);
		logic [BYTE_W-1:0] bytes_out [MAX_RESULTS];
		logic [1:0]        stat;
		logic              carried, drained, have_data;
		logic [BYTE_W-1:0] txl, rxl;
		int                n, plen, room;
		buf_word_t         w;
		stat    = STAT_OK;
		carried = 1'b0;
		drained = 1'b0;
		n       = 1;
		foreach (bytes_out[k])
			bytes_out[k] = '0;
		case (op)
		CMD_PUSH: begin
			if (fill_level(tx_rd, tx_wr) == 8'hff) begin
				stat = STAT_TX_FULL;
			end else begin
				tx_ring[tx_wr] = din;
				tx_wr = tx_wr + 8'd1;
			end
		end
		CMD_POP: begin
			if (fill_level(rx_rd, rx_wr) == 8'h00) begin
				stat = STAT_RX_EMPTY;
			end else begin
				bytes_out[0] = rx_ring[rx_rd];
				rx_rd = rx_rd + 8'd1;
				carried = 1'b1;
			end
		end
		CMD_RECV: begin
			if (fill_level(rx_rd, rx_wr) == 8'hff) begin
				stat = STAT_RX_DROP;
			end else begin
				rx_ring[rx_wr] = din;
				rx_wr = rx_wr + 8'd1;
			end
		end
		CMD_REQ: begin
			plen = (cfg_plen > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(cfg_plen);
			have_data = fill_level(tx_rd, tx_wr) != 8'h00;
			// empty ring drops into idle mode with a fresh pattern
			if (!have_data && !idle_fill) begin
				idle_fill = 1'b1;
				fill_pos = '0;
			end
			// a finished pattern restarts, or hands over to waiting data
			if (idle_fill && int'(fill_pos) >= plen) begin
				if (have_data)
					idle_fill = 1'b0;
				fill_pos = '0;
			end
			if (idle_fill) begin
				room = (space > MAX_RESULTS) ? MAX_RESULTS : int'(space);
				n = 0;
				while (n < room && int'(fill_pos) < plen) begin
					bytes_out[n] = (fill_pos < PBYTES_N) ?
						cfg_pattern[8*fill_pos +: 8] : 8'h00;
					fill_pos = fill_pos + 1'b1;
					n++;
				end
				if (n > 0)
					carried = 1'b1;
				else
					n = 1;
			end else begin
				bytes_out[0] = tx_ring[tx_rd];
				tx_rd = tx_rd + 8'd1;
				carried = 1'b1;
				drained = fill_level(tx_rd, tx_wr) == 8'h00;
			end
		end
		endcase

		txl = fill_level(tx_rd, tx_wr);
		rxl = fill_level(rx_rd, rx_wr);
		for (int k = 0; k < n; k++) begin
			w.status     = stat;
			w.byte_valid = carried;
			w.data_out   = carried ? bytes_out[k] : 8'h00;
			w.last       = (k == n - 1);
			w.tx_level   = txl;
			w.rx_level   = rxl;
			w.rx_ready   = (cfg_thresh != 8'h00) && (rxl >= cfg_thresh);
			w.tx_drained = drained;
			owed_words.push_back(w);
		end
	endfunction

	function void compare(input string field, input logic [31:0] want,
			input logic [31:0] seen);
		if (seen !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
		end
	endfunction

	// check one word from the block against the oldest one owed
	function void check_word(input buf_word_t seen);
		buf_word_t want;
		if (owed_words.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected word, expected none, actual %h", $time, seen);
			return;
		end
		want = owed_words.pop_front();
		compare("status", want.status, seen.status);
		compare("byte_valid", want.byte_valid, seen.byte_valid);
		compare("data_out", want.data_out, seen.data_out);
		compare("last", want.last, seen.last);
		compare("tx_level", want.tx_level, seen.tx_level);
		compare("rx_level", want.rx_level, seen.rx_level);
		compare("rx_ready", want.rx_ready, seen.rx_ready);
		compare("tx_drained", want.tx_drained, seen.tx_drained);
	endfunction
endclass

module tb;
	localparam int HOLD_CYCLES = 150;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [1:0]          cfg_index;
	logic [PBYTES_W-1:0] cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          cmd;
	logic [BYTE_W-1:0]   data_in;
	logic [2:0]          fifo_space;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          status;
	logic                byte_valid;
	logic [BYTE_W-1:0]   data_out;
	logic                last;
	logic [BYTE_W-1:0]   tx_level;
	logic [BYTE_W-1:0]   rx_level;
	logic                rx_ready;
	logic                tx_drained;

	buffer_tracker book = new();
	int            send_gap_pct = 0;
	int            sink_gap_pct = 0;
	int            hold_reqs = 0;
	int            items_sent = 0;
	int            quiet_cycles = 0;

	i2c_target_buffer_with_idle_fill_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.data_in    (data_in),
		.fifo_space (fifo_space),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.byte_valid (byte_valid),
		.data_out   (data_out),
		.last       (last),
		.tx_level   (tx_level),
		.rx_level   (rx_level),
		.rx_ready   (rx_ready),
		.tx_drained (tx_drained)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// no progress on any channel for too long ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: check accepted words, then pick next cycle's ready
	initial begin : result_sink
		int stall_left;
		int seen_holds;
		stall_left = 0;
		seen_holds = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				book.check_word({status, byte_valid, data_out, last,
					tx_level, rx_level, rx_ready, tx_drained});
			if (hold_reqs != seen_holds) begin
				seen_holds = hold_reqs;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= sink_gap_pct);
			end
		end
	end

	// offer one command word and hold it until taken
	task automatic send_item(input logic [1:0] op, input logic [BYTE_W-1:0] din,
			input logic [2:0] space);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		data_in    <= din;
		fifo_space <= space;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		book.apply_command(op, din, space);
		items_sent++;
	endtask

	// stop offering and let every owed word come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (book.owed() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [PBYTES_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		book.write_reg(idx, val);
	endtask

	task automatic load_config(input logic [PLEN_W-1:0] plen,
			input logic [PBYTES_W-1:0] pat, input logic [BYTE_W-1:0] thr);
		wait_drained();
		cfg_write(CFG_PATTERN_LENGTH, PBYTES_W'(plen));
		cfg_write(CFG_PATTERN_BYTES, pat);
		cfg_write(CFG_RX_THRESHOLD, PBYTES_W'(thr));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] any_byte();
		return BYTE_W'($urandom_range(255));
	endfunction

	function automatic logic [2:0] any_space();
		return 3'($urandom_range(7));
	endfunction

	// mostly well-formed transfers with random content, some plain noise
	task automatic random_traffic(input int target);
		int stop_at;
		int kind;
		int k;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			kind = $urandom_range(9);
			k = $urandom_range(1, 5);
			if (kind < 3) begin
				// host loads bytes, bus takes them, extra requests go to filler
				repeat (k) send_item(CMD_PUSH, any_byte(), any_space());
				repeat (k + $urandom_range(2)) send_item(CMD_REQ, any_byte(), any_space());
			end else if (kind < 5) begin
				// bus delivers bytes, host collects them, maybe one pop too many
				repeat (k) send_item(CMD_RECV, any_byte(), any_space());
				repeat (k + $urandom_range(1)) send_item(CMD_POP, any_byte(), any_space());
			end else if (kind < 7) begin
				repeat ($urandom_range(1, 3)) send_item(CMD_REQ, any_byte(), any_space());
			end else begin
				repeat (k) send_item(2'($urandom_range(3)), any_byte(), any_space());
			end
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_index  <= CFG_PATTERN_LENGTH;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		cmd        <= CMD_PUSH;
		data_in    <= '0;
		fifo_space <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset pattern, empty pop, idle filler, space above four
		sink_gap_pct = 58;
		send_item(CMD_POP, 8'h00, 3'd0);
		send_item(CMD_REQ, 8'h00, 3'd4);
		send_item(CMD_REQ, 8'hff, 3'd0);
		send_item(CMD_REQ, 8'h00, 3'd7);
		send_item(CMD_PUSH, 8'h00, 3'd0);
		send_item(CMD_PUSH, 8'hff, 3'd7);
		send_item(CMD_REQ, 8'h00, 3'd1);
		send_item(CMD_REQ, 8'h00, 3'd0);
		send_item(CMD_RECV, 8'hff, 3'd0);
		send_item(CMD_RECV, 8'h00, 3'd7);
		send_item(CMD_POP, 8'h00, 3'd0);
		send_item(CMD_POP, 8'hff, 3'd0);

		// four byte pattern, data arriving part way through a pattern
		load_config(3'd4, 32'hffff_ffff, 8'd1);
		send_item(CMD_REQ, 8'h00, 3'd2);
		send_item(CMD_RECV, 8'h5a, 3'd0);
		send_item(CMD_PUSH, 8'h81, 3'd0);
		send_item(CMD_REQ, 8'h00, 3'd3);
		send_item(CMD_REQ, 8'h00, 3'd4);
		send_item(CMD_REQ, 8'h00, 3'd3);

		// pattern shortened while in idle mode leaves the index past the end
		load_config(3'd1, 32'h0000_0000, 8'd255);
		send_item(CMD_REQ, 8'h00, 3'd4);
		send_item(CMD_PUSH, 8'h3c, 3'd0);
		send_item(CMD_REQ, 8'h00, 3'd4);

		// empty pattern sends nothing
		load_config(3'd0, 32'h0000_0000, 8'd255);
		send_item(CMD_REQ, 8'h00, 3'd4);
		send_item(CMD_POP, 8'h00, 3'd0);

		// random phases with shifting idle balance
		load_config(3'd2, $urandom, 8'd3);
		send_gap_pct = 7;
		sink_gap_pct = 58;
		random_traffic(115);

		load_config(3'd7, $urandom, BYTE_W'($urandom_range(1, 8)));
		send_gap_pct = 58;
		sink_gap_pct = 7;
		random_traffic(115);

		load_config(3'($urandom_range(7)), $urandom, 8'd0);
		send_gap_pct = 0;
		sink_gap_pct = 0;
		random_traffic(120);

		// flood both rings past full while the output is held off
		load_config(3'd4, $urandom, 8'd255);
		hold_reqs <= hold_reqs + 1;
		repeat (258) send_item(CMD_PUSH, any_byte(), any_space());
		repeat (258) send_item(CMD_RECV, any_byte(), any_space());
		repeat (20) begin
			send_item(CMD_POP, any_byte(), any_space());
			send_item(CMD_REQ, any_byte(), any_space());
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (book.mismatches == 0 && book.owed() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule
